[hw/rtl/fcr_pkg.sv]
// package for the flash controller register block
// shared types, constants and codes; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package fcr_pkg;
    localparam int PagesPerBank = 4;
    localparam int PageBytes    = 2048;
    localparam int DwDepth      = 2048;
    localparam int DwAw         = 11;
    localparam logic [9:0] DW_PER_PAGE = 10'(PageBytes / 8);

    localparam logic [31:0] KEY_FIRST  = 32'h4567_0123;
    localparam logic [31:0] KEY_SECOND = 32'hCDEF_89AB;

    localparam logic [2:0] REQ_REG_RD = 3'd0;
    localparam logic [2:0] REQ_REG_WR = 3'd1;
    localparam logic [2:0] REQ_ARR_WR = 3'd2;
    localparam logic [2:0] REQ_ARR_RD = 3'd3;
    localparam logic [2:0] REQ_TICK   = 3'd4;

    localparam logic [5:0] OFF_KEYR = 6'h08;
    localparam logic [5:0] OFF_SR   = 6'h10;
    localparam logic [5:0] OFF_CR   = 6'h14;

    localparam logic [7:0] F_EOP     = 8'h01;
    localparam logic [7:0] F_PROGERR = 8'h08;
    localparam logic [7:0] F_PGAERR  = 8'h20;
    localparam logic [7:0] F_PGSERR  = 8'h80;
    localparam logic [7:0] ERR_MASK  = 8'hFA;
    localparam logic [7:0] SR_MASK   = 8'hFB;
    localparam logic [11:0] CTRL_MASK = 12'hFFB;

    // commands from controller to datapath
    typedef struct packed {
        logic        load;     // latch request fields, issue array read
        logic        execute;  // commit the item using array read data
        logic        clear;    // erase-state sweep step
        logic [DwAw-1:0] clear_addr;
    } fcr_cmd_t;

    typedef struct packed {
        logic busy;
        logic locked;
    } fcr_status_t;
endpackage
`default_nettype wire

[hw/rtl/fcr_ram.sv]
// generic single-port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module fcr_ram #(
    parameter int Width = 64,
    parameter int Depth = 2048
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] addr,
    input  wire logic [Width-1:0]         wdata,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

[hw/rtl/fcr_datapath.sv]
// datapath: registers, key logic, pending program word and flash array
// depends on fcr_pkg and fcr_ram
`timescale 1ns / 1ps
`default_nettype none
module fcr_datapath (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire fcr_pkg::fcr_cmd_t     cmd,
    input  wire logic [7:0]            program_ticks,
    input  wire logic [2:0]            req_type,
    input  wire logic [5:0]            reg_offset,
    input  wire logic [13:0]           array_offset,
    input  wire logic [31:0]           wdata,
    output logic      [31:0]           rdata,
    output fcr_pkg::fcr_status_t       status
);
    import fcr_pkg::*;

    logic [2:0]  req_reg;
    logic [5:0]  roff_reg;
    logic [13:0] aoff_reg;
    logic [31:0] wd_reg;
    logic        lock_reg, lock_next;
    logic        kst_reg, kst_next;
    logic        klo_reg, klo_next;
    logic [11:0] ctrl_reg, ctrl_next;
    logic [7:0]  sr_reg, sr_next;
    logic [9:0]  bcnt_reg, bcnt_next;
    logic [DwAw-1:0] ebase_reg, ebase_next;
    logic [31:0] plow_reg, plow_next;
    logic [13:0] paddr_reg, paddr_next;
    logic        pv_reg, pv_next;
    logic [31:0] rd_next;

    logic            ram_we;
    logic [DwAw-1:0] ram_addr;
    logic [63:0]     ram_wdata, ram_rdata;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg  <= req_type;
            roff_reg <= reg_offset;
            aoff_reg <= array_offset;
            wd_reg   <= wdata;
        end
    end

    // array address: sweep, erase write, program write, or lookup
    always_comb begin
        ram_we    = 1'b0;
        ram_wdata = '1;
        ram_addr  = array_offset[DwAw+2:3];
        if (cmd.clear) begin
            ram_we   = 1'b1;
            ram_addr = cmd.clear_addr;
        end else if (cmd.execute) begin
            ram_addr = aoff_reg[DwAw+2:3];
            if (req_reg == REQ_TICK && bcnt_reg != '0 && ctrl_reg[1]) begin
                ram_we   = 1'b1;
                ram_addr = ebase_reg;
            end else if (req_reg == REQ_ARR_WR && !lock_reg && bcnt_reg == '0
                         && ctrl_reg[0] && !ctrl_reg[1] && (sr_reg & ERR_MASK) == '0
                         && aoff_reg[1:0] == 2'b00 && pv_reg
                         && aoff_reg == paddr_reg + 14'd4
                         && (ram_rdata == '1 || {wd_reg, plow_reg} == '0)) begin
                ram_we    = 1'b1;
                ram_wdata = {wd_reg, plow_reg};
            end
        end
    end

    fcr_ram #(.Width(64), .Depth(DwDepth)) u_ram (
        .aclk (aclk), .we (ram_we), .addr (ram_addr),
        .wdata (ram_wdata), .rdata (ram_rdata)
    );

    always_comb begin
        lock_next = lock_reg; kst_next = kst_reg; klo_next = klo_reg;
        ctrl_next = ctrl_reg; sr_next = sr_reg; bcnt_next = bcnt_reg;
        ebase_next = ebase_reg; plow_next = plow_reg; paddr_next = paddr_reg;
        pv_next = pv_reg; rd_next = '0;
        case (req_reg)
            REQ_REG_RD: begin
                if (roff_reg == OFF_SR)
                    rd_next = {15'd0, bcnt_reg != '0, 8'd0, sr_reg};
                else if (roff_reg == OFF_CR)
                    rd_next = {lock_reg, 19'd0, ctrl_reg};
            end
            REQ_REG_WR: begin
                if (roff_reg == OFF_KEYR) begin
                    if (lock_reg && !klo_reg) begin
                        if (!kst_reg) begin
                            if (wd_reg == KEY_FIRST) kst_next = 1'b1;
                            else klo_next = 1'b1;
                        end else begin
                            if (wd_reg == KEY_SECOND) lock_next = 1'b0;
                            else klo_next = 1'b1;
                            kst_next = 1'b0;
                        end
                    end
                end else if (roff_reg == OFF_SR) begin
                    sr_next = sr_reg & ~(wd_reg[7:0] & SR_MASK);
                end else if (roff_reg == OFF_CR) begin
                    if (!lock_reg && bcnt_reg == '0) begin
                        ctrl_next = wd_reg[11:0] & CTRL_MASK;
                        if (wd_reg[16] && wd_reg[1]) begin
                            if (wd_reg[0] || (sr_reg & ERR_MASK) != '0) begin
                                sr_next = sr_reg | F_PGSERR;
                            end else begin
                                ebase_next = DwAw'(32'({1'b0, wd_reg[10:3]}
                                    + (wd_reg[11] ? 9'(PagesPerBank) : 9'd0))
                                    * 32'(DW_PER_PAGE));
                                bcnt_next = DW_PER_PAGE;
                            end
                        end
                        if (wd_reg[31]) begin
                            lock_next = 1'b1;
                            kst_next  = 1'b0;
                        end
                    end
                end
            end
            REQ_ARR_WR: begin
                if (!lock_reg && bcnt_reg == '0 && ctrl_reg[0]) begin
                    if (ctrl_reg[1] || (sr_reg & ERR_MASK) != '0) begin
                        sr_next = sr_reg | F_PGSERR;
                        pv_next = 1'b0;
                    end else if (aoff_reg[1:0] != 2'b00) begin
                        sr_next = sr_reg | F_PGAERR;
                        pv_next = 1'b0;
                    end else if (!pv_reg) begin
                        if (aoff_reg[2]) begin
                            sr_next = sr_reg | F_PGAERR;
                        end else begin
                            plow_next = wd_reg; paddr_next = aoff_reg; pv_next = 1'b1;
                        end
                    end else begin
                        pv_next = 1'b0;
                        if (aoff_reg != paddr_reg + 14'd4) begin
                            sr_next = sr_reg | F_PGAERR;
                        end else begin
                            if (ram_rdata != '1 && {wd_reg, plow_reg} != '0)
                                sr_next = sr_reg | F_PROGERR;
                            bcnt_next = {2'b00, program_ticks};
                            if (program_ticks == '0) sr_next = sr_next | F_EOP;
                        end
                    end
                end
            end
            REQ_ARR_RD: begin
                rd_next = aoff_reg[2] ? ram_rdata[63:32] : ram_rdata[31:0];
            end
            REQ_TICK: begin
                if (bcnt_reg != '0) begin
                    if (ctrl_reg[1]) ebase_next = ebase_reg + 1'b1;
                    bcnt_next = bcnt_reg - 1'b1;
                    if (bcnt_reg == 10'd1) sr_next = sr_reg | F_EOP;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lock_reg <= 1'b1; kst_reg <= 1'b0; klo_reg <= 1'b0; ctrl_reg <= '0;
            sr_reg <= '0; bcnt_reg <= '0; ebase_reg <= '0; plow_reg <= '0;
            paddr_reg <= '0; pv_reg <= 1'b0;
        end else if (cmd.execute) begin
            lock_reg <= lock_next; kst_reg <= kst_next; klo_reg <= klo_next;
            ctrl_reg <= ctrl_next; sr_reg <= sr_next; bcnt_reg <= bcnt_next;
            ebase_reg <= ebase_next; plow_reg <= plow_next;
            paddr_reg <= paddr_next; pv_reg <= pv_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.execute) rdata <= rd_next;
    end

    assign status.busy   = bcnt_reg != '0;
    assign status.locked = lock_reg;

    // a lockout keeps the controller locked
    assert property (@(posedge aclk) disable iff (!aresetn) klo_reg |-> lock_reg)
        else $error("lockout without lock");
    // busy count never exceeds a page
    assert property (@(posedge aclk) disable iff (!aresetn)
        bcnt_reg <= 10'd255 || bcnt_reg <= DW_PER_PAGE) else $error("busy count range");
    // state changes only when an item executes
    assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(cmd.execute) && $past(aresetn) |-> $stable(sr_reg))
        else $error("status changed while idle");
endmodule
`default_nettype wire

[hw/rtl/fcr_ctrl.sv]
// controller: clearing sweep, item sequencing and output handshake
// depends on fcr_pkg
`timescale 1ns / 1ps
`default_nettype none
module fcr_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output fcr_pkg::fcr_cmd_t      cmd
);
    import fcr_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_EXEC  = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [DwAw-1:0] clr_reg, clr_next;

    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        cmd        = '0;
        cmd.clear_addr = clr_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == DwAw'(DwDepth - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                cmd.execute = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT: begin
                m_valid = 1'b1;
                // result register frees as the next item is taken
                s_ready  = m_ready;
                cmd.load = m_ready && s_valid;
                if (m_ready) state_next = s_valid ? ST_EXEC : ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot({cmd.load && !s_ready, cmd.execute, cmd.clear, 1'b0}) ||
        !(cmd.execute || cmd.clear)) else $error("command overlap");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.execute |=> m_valid) else $error("result not presented");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear |-> !s_ready) else $error("accept during clear");
endmodule
`default_nettype wire

[hw/rtl/flash_controller_registers.sv]
// top level of the flash controller register block
// depends on fcr_pkg, fcr_ctrl, fcr_datapath
`timescale 1ns / 1ps
`default_nettype none
// Each item is first latched, with the flash array read issued, and then
// committed; the result then waits in an output register and the next item is
// taken in the same cycle it is consumed. The single array port sets this
// split. After reset the 2048-entry array is swept to all ones, one double-word
// a cycle, before s_ready first rises; configuration writes are taken at any
// time.
module flash_controller_registers (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_req_type,
    input  wire logic [5:0]  s_reg_offset,
    input  wire logic [13:0] s_array_offset,
    input  wire logic [31:0] s_wdata,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [31:0] m_rdata,
    output logic             m_busy_res,
    output logic             m_locked
);
    import fcr_pkg::*;

    fcr_cmd_t    cmd;
    fcr_status_t status;
    logic [7:0]  ticks_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) ticks_reg <= 8'd4;
        else if (cfg_valid) ticks_reg <= cfg_data;
    end

    fcr_ctrl u_ctrl (
        .aclk (aclk), .aresetn (aresetn), .s_valid (s_valid), .s_ready (s_ready),
        .m_valid (m_valid), .m_ready (m_ready), .cmd (cmd)
    );

    fcr_datapath u_dp (
        .aclk (aclk), .aresetn (aresetn), .cmd (cmd), .program_ticks (ticks_reg),
        .req_type (s_req_type), .reg_offset (s_reg_offset),
        .array_offset (s_array_offset), .wdata (s_wdata),
        .rdata (m_rdata), .status (status)
    );

    assign m_busy_res = status.busy;
    assign m_locked   = status.locked;
endmodule
`default_nettype wire
